// File: rtl/core/source_token_lexer_macros.svh
// assertion macros shared by the lexer modules
`ifndef SOURCE_TOKEN_LEXER_MACROS_SVH
`define SOURCE_TOKEN_LEXER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define STL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer check failed");

// consequent checked in the cycle after the antecedent
`define STL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

// File: rtl/core/stl_pkg.sv
// types, codes and character tables of the source token lexer
`default_nettype none
package stl_pkg;

  localparam int WordDepth = 12;
  localparam int WlenW     = $clog2(WordDepth + 1);
  localparam int WaddrW    = $clog2(WordDepth);
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic [3:0] M_IDLE = 4'd0, M_IDENT = 4'd1, M_NUM_ZERO = 4'd2,
    M_NUM_HEXPFX = 4'd3, M_NUM = 4'd4, M_OP1 = 4'd5, M_OP2 = 4'd6, M_LINE = 4'd7,
    M_BLOCK = 4'd8, M_LIT = 4'd9, M_ESC = 4'd10, M_HEX1 = 4'd11, M_HEX2 = 4'd12,
    M_OCT = 4'd13;

  localparam logic [4:0] K_SINGLE = 5'd0, K_IDENT = 5'd23, K_KEYWORD = 5'd24,
    K_NUMBER = 5'd25, K_STRING = 5'd26, K_END = 5'd27, K_TEXT = 5'd28;
  localparam logic [4:0] OP_STAR_EQ = 5'd1, OP_PCT_EQ = 5'd2, OP_TILDE_EQ = 5'd3,
    OP_EQ_EQ = 5'd4, OP_NOT_EQ = 5'd5, OP_SHL_EQ = 5'd6, OP_SHR_EQ = 5'd7,
    OP_SHL = 5'd8, OP_SHR = 5'd9, OP_LE = 5'd10, OP_GE = 5'd11, OP_ADD_EQ = 5'd12,
    OP_SUB_EQ = 5'd13, OP_OR_EQ = 5'd14, OP_AND_EQ = 5'd15, OP_INC = 5'd16,
    OP_DEC = 5'd17, OP_LOR = 5'd18, OP_LAND = 5'd19, OP_ELLIPSIS = 5'd20,
    OP_DOTDOT = 5'd21, OP_DIV_EQ = 5'd22;

  localparam logic [2:0] E_NONE = 3'd0, E_BAD_NUM = 3'd1, E_UNTERM = 3'd2,
    E_NO_HEX = 3'd3, E_MULTI = 3'd4, E_EMPTY = 3'd5, E_ESCAPE = 3'd6;

  localparam logic [1:0] B_DEC = 2'd0, B_OCT = 2'd1, B_HEX = 2'd2;

  localparam logic [63:0] I64Max = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] ChDquote = 8'h22, ChSquote = 8'h27, ChBslash = 8'h5C,
    ChNl = 8'h0A;

  localparam int KwCount = 19;
  localparam logic [87:0] KwText [KwCount] = '{"as", "break", "case", "continue",
    "default", "define", "else", "fallthrough", "false", "for", "goto", "if",
    "include", "nil", "return", "sizeof", "switch", "true", "type"};
  localparam int KwLen [KwCount] = '{2, 5, 4, 8, 7, 6, 4, 11, 5, 3, 4, 2, 7, 3,
    6, 6, 6, 4, 4};

  typedef struct packed {
    logic [3:0]       mode;
    logic [7:0]       pend;
    logic [WlenW-1:0] wlen;
    logic             wlong;
    logic [63:0]      nval;
    logic [1:0]       nbase;
    logic             ninv;
    logic             qkind;
    logic [8:0]       eval;
    logic [1:0]       edig;
    logic [1:0]       ccount;
    logic [7:0]       fchar;
    logic             halted;
  } stl_state_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    logic [2:0]  err;
  } stl_res_t;

  typedef struct packed {
    logic     v;
    stl_res_t r;
  } stl_emit_t;

  typedef struct packed {
    logic [1:0] cnt;
    stl_res_t   r0;
    stl_res_t   r1;
  } stl_push_t;

  typedef struct packed {
    logic              v;
    logic [WaddrW-1:0] addr;
  } stl_wr_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_idnum(logic [7:0] c);
    return is_alpha(c) || is_dig(c);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] t;
    if (is_dig(c)) t = c - "0";
    else if (c >= "a" && c <= "f") t = c - "a" + 8'd10;
    else t = c - "A" + 8'd10;
    return t[3:0];
  endfunction

  function automatic logic is_opstart(logic [7:0] c);
    return c == "*" || c == "%" || c == "~" || c == "=" || c == "!" ||
           c == "<" || c == ">" || c == "+" || c == "-" || c == "|" ||
           c == "&" || c == "." || c == "/";
  endfunction

  function automatic logic [4:0] op_pair(logic [7:0] p, logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c == "=") begin
      unique case (p)
        "*": r = OP_STAR_EQ;
        "%": r = OP_PCT_EQ;
        "~": r = OP_TILDE_EQ;
        "=": r = OP_EQ_EQ;
        "!": r = OP_NOT_EQ;
        "<": r = OP_LE;
        ">": r = OP_GE;
        "+": r = OP_ADD_EQ;
        "-": r = OP_SUB_EQ;
        "|": r = OP_OR_EQ;
        "&": r = OP_AND_EQ;
        "/": r = OP_DIV_EQ;
        default: r = 5'd0;
      endcase
    end else if (c == p) begin
      unique case (p)
        "+": r = OP_INC;
        "-": r = OP_DEC;
        "|": r = OP_LOR;
        "&": r = OP_LAND;
        default: r = 5'd0;
      endcase
    end
    return r;
  endfunction

  // {hit, index}; entry k of the buffer sits at bits [k*8 +: 8]
  function automatic logic [5:0] kw_match(logic [WordDepth*8-1:0] wb,
                                          logic [WlenW-1:0] len);
    logic       hit;
    logic [4:0] idx;
    logic       ok;
    hit = 1'b0;
    idx = 5'd0;
    for (int i = 0; i < KwCount; i++) begin
      ok = (len == WlenW'(KwLen[i])) && (KwLen[i] <= WordDepth);
      for (int k = 0; k < KwLen[i]; k++) begin
        ok = ok && (wb[k*8 +: 8] == KwText[i][(KwLen[i]-1-k)*8 +: 8]);
      end
      if (ok && !hit) begin
        hit = 1'b1;
        idx = 5'(i);
      end
    end
    return {hit, idx};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/stl_step.sv
// next-state and result logic for one source character or end marker
`default_nettype none
module stl_step (
  input  stl_pkg::stl_state_t            st_i,
  input  logic [stl_pkg::WordDepth*8-1:0] wbuf_i,
  input  logic [7:0]                      byte_i,
  input  logic                            eoi_i,
  output stl_pkg::stl_state_t            st_o,
  output stl_pkg::stl_wr_t               wr_o,
  output stl_pkg::stl_push_t             push_o
);
  import stl_pkg::*;

  typedef struct packed {
    stl_state_t st;
    stl_emit_t  em;
    stl_wr_t    wr;
  } stl_upd_t;

  function automatic stl_emit_t mk(logic [4:0] k, logic [63:0] v, logic [2:0] e);
    stl_emit_t m;
    m.v = 1'b1;
    m.r.kind = k;
    m.r.value = v;
    m.r.err = e;
    return m;
  endfunction

  function automatic stl_upd_t f_fatal(stl_state_t s, logic [2:0] e);
    stl_upd_t u;
    u = '0;
    u.st = s;
    u.em = mk(s.qkind ? K_STRING : K_NUMBER, 64'd0, e);
    u.st.halted = 1'b1;
    u.st.mode = M_IDLE;
    return u;
  endfunction

  function automatic stl_upd_t f_litbyte(stl_state_t s, logic [7:0] b, logic [2:0] e);
    stl_upd_t u;
    u = '0;
    u.st = s;
    u.em = mk(K_TEXT, {56'd0, b}, e);
    if (s.ccount == 2'd0) u.st.fchar = b;
    if (s.ccount < 2'd2) u.st.ccount = s.ccount + 2'd1;
    return u;
  endfunction

  function automatic stl_upd_t f_idle(stl_state_t s, logic [7:0] c);
    stl_upd_t u;
    u = '0;
    u.st = s;
    if (is_space(c)) begin
      u.st = s;
    end else if (is_alpha(c)) begin
      u.wr.v = 1'b1;
      u.wr.addr = '0;
      u.st.wlen = WlenW'(1);
      u.st.wlong = 1'b0;
      u.em = mk(K_TEXT, {56'd0, c}, E_NONE);
      u.st.mode = M_IDENT;
    end else if (is_dig(c)) begin
      u.st.nval = {56'd0, c - "0"};
      u.st.nbase = B_DEC;
      u.st.ninv = 1'b0;
      u.st.mode = (c == "0") ? M_NUM_ZERO : M_NUM;
    end else if (c == ChSquote || c == ChDquote) begin
      u.st.qkind = (c == ChDquote);
      u.st.ccount = 2'd0;
      u.st.fchar = 8'd0;
      u.st.mode = M_LIT;
    end else if (is_opstart(c)) begin
      u.st.pend = c;
      u.st.mode = M_OP1;
    end else begin
      u.em = mk(K_SINGLE, {56'd0, c}, E_NONE);
    end
    return u;
  endfunction

  function automatic stl_upd_t f_lit(stl_state_t s, logic [7:0] c);
    stl_upd_t u;
    u = '0;
    u.st = s;
    if (c == ChNl) begin
      u = f_fatal(s, E_UNTERM);
    end else if (c == (s.qkind ? ChDquote : ChSquote)) begin
      u.st.mode = M_IDLE;
      if (s.qkind) u.em = mk(K_STRING, 64'd0, E_NONE);
      else if (s.ccount == 2'd0) u.em = mk(K_NUMBER, 64'd0, E_EMPTY);
      else if (s.ccount == 2'd1) u.em = mk(K_NUMBER, {56'd0, s.fchar}, E_NONE);
      else begin
        u.em = mk(K_NUMBER, {56'd0, s.fchar}, E_MULTI);
        u.st.halted = 1'b1;
      end
    end else if (c == ChBslash) begin
      u.st.mode = M_ESC;
    end else begin
      u = f_litbyte(s, c, E_NONE);
    end
    return u;
  endfunction

  function automatic stl_emit_t close_num(stl_state_t s, logic inv);
    return mk(K_NUMBER, s.nval, inv ? E_BAD_NUM : E_NONE);
  endfunction

  function automatic stl_emit_t op2_tok(stl_state_t s);
    if (s.pend == ".") return mk(OP_DOTDOT, 64'd0, E_NONE);
    return mk((s.pend == "<") ? OP_SHL : OP_SHR, 64'd0, E_NONE);
  endfunction

  stl_upd_t   u1, u2;
  logic       redo_idle, redo_lit, fatal;
  logic [5:0] kw;
  logic [4:0] op;
  logic [3:0] h;
  logic       dig_ok;
  logic [67:0] prod;
  logic [8:0]  oct_v;
  logic [7:0]  c;

  assign c  = byte_i;
  assign kw = kw_match(wbuf_i, st_i.wlen);
  assign op = op_pair(st_i.pend, c);
  assign h  = hex_val(c);

  // accumulate one digit; saturation when the product passes the signed maximum
  always_comb begin
    unique case (st_i.nbase)
      B_HEX:   prod = {st_i.nval, 4'd0} + {64'd0, h};
      B_OCT:   prod = {1'b0, st_i.nval, 3'd0} + {64'd0, h};
      default: prod = {1'b0, st_i.nval, 3'd0} + {3'd0, st_i.nval, 1'b0} + {64'd0, h};
    endcase
    unique case (st_i.nbase)
      B_HEX:   dig_ok = is_hex(c);
      B_OCT:   dig_ok = c >= "0" && c <= "7";
      default: dig_ok = is_dig(c);
    endcase
  end

  assign oct_v = {st_i.eval[5:0], 3'd0} + {6'd0, c[2:0]};

  always_comb begin
    u1 = '0;
    u1.st = st_i;
    redo_idle = 1'b0;
    redo_lit = 1'b0;
    fatal = 1'b0;
    if (st_i.halted) begin
      u1.st = st_i;
    end else if (eoi_i) begin
      unique case (st_i.mode)
        M_IDENT: u1.em = (kw[5] && !st_i.wlong) ? mk(K_KEYWORD, {59'd0, kw[4:0]}, E_NONE)
                                                : mk(K_IDENT, 64'd0, E_NONE);
        M_NUM_HEXPFX: u1.em = close_num(st_i, 1'b1);
        M_NUM_ZERO, M_NUM: u1.em = close_num(st_i, st_i.ninv);
        M_OP1: u1.em = mk(K_SINGLE, {56'd0, st_i.pend}, E_NONE);
        M_OP2: u1.em = op2_tok(st_i);
        M_LIT, M_ESC, M_HEX2, M_OCT: begin
          u1 = f_fatal(st_i, E_UNTERM);
          fatal = 1'b1;
        end
        M_HEX1: begin
          u1 = f_fatal(st_i, E_NO_HEX);
          fatal = 1'b1;
        end
        default: u1.em = '0;
      endcase
      if (!fatal) u1.st = '0;
    end else begin
      unique case (st_i.mode)
        M_IDLE: redo_idle = 1'b1;
        M_IDENT: begin
          if (is_idnum(c)) begin
            if (st_i.wlen < WlenW'(WordDepth)) begin
              u1.wr.v = 1'b1;
              u1.wr.addr = st_i.wlen[WaddrW-1:0];
              u1.st.wlen = st_i.wlen + WlenW'(1);
            end else begin
              u1.st.wlong = 1'b1;
            end
            u1.em = mk(K_TEXT, {56'd0, c}, E_NONE);
          end else begin
            u1.em = (kw[5] && !st_i.wlong) ? mk(K_KEYWORD, {59'd0, kw[4:0]}, E_NONE)
                                           : mk(K_IDENT, 64'd0, E_NONE);
            u1.st.mode = M_IDLE;
            redo_idle = 1'b1;
          end
        end
        M_NUM_ZERO: begin
          if (c == "x" || c == "X") begin
            u1.st.mode = M_NUM_HEXPFX;
          end else if (is_idnum(c)) begin
            u1.st.nbase = B_OCT;
            u1.st.mode = M_NUM;
            if (c >= "0" && c <= "7") u1.st.nval = {56'd0, c - "0"};
            else u1.st.ninv = 1'b1;
          end else begin
            u1.em = close_num(st_i, st_i.ninv);
            u1.st.mode = M_IDLE;
            redo_idle = 1'b1;
          end
        end
        M_NUM_HEXPFX: begin
          if (is_hex(c)) begin
            u1.st.nbase = B_HEX;
            u1.st.nval = {60'd0, h};
            u1.st.mode = M_NUM;
          end else if (is_idnum(c)) begin
            u1.st.nbase = B_HEX;
            u1.st.ninv = 1'b1;
            u1.st.mode = M_NUM;
          end else begin
            u1.st.ninv = 1'b1;
            u1.em = close_num(st_i, 1'b1);
            u1.st.mode = M_IDLE;
            redo_idle = 1'b1;
          end
        end
        M_NUM: begin
          if (!st_i.ninv && dig_ok) begin
            u1.st.nval = (prod > {4'd0, I64Max}) ? I64Max : prod[63:0];
          end else if (is_idnum(c)) begin
            u1.st.ninv = 1'b1;
          end else begin
            u1.em = close_num(st_i, st_i.ninv);
            u1.st.mode = M_IDLE;
            redo_idle = 1'b1;
          end
        end
        M_OP1: begin
          if (op != 5'd0) begin
            u1.em = mk(op, 64'd0, E_NONE);
            u1.st.mode = M_IDLE;
          end else if (c == st_i.pend && (c == "<" || c == ">" || c == ".")) begin
            u1.st.mode = M_OP2;
          end else if (st_i.pend == "/" && c == "/") begin
            u1.st.mode = M_LINE;
          end else if (st_i.pend == "/" && c == "*") begin
            u1.st.pend = 8'd0;
            u1.st.mode = M_BLOCK;
          end else begin
            u1.em = mk(K_SINGLE, {56'd0, st_i.pend}, E_NONE);
            u1.st.mode = M_IDLE;
            redo_idle = 1'b1;
          end
        end
        M_OP2: begin
          u1.st.mode = M_IDLE;
          if (st_i.pend == "." && c == ".") begin
            u1.em = mk(OP_ELLIPSIS, 64'd0, E_NONE);
          end else if (st_i.pend != "." && c == "=") begin
            u1.em = mk((st_i.pend == "<") ? OP_SHL_EQ : OP_SHR_EQ, 64'd0, E_NONE);
          end else begin
            u1.em = op2_tok(st_i);
            redo_idle = 1'b1;
          end
        end
        M_LINE: if (c == ChNl) u1.st.mode = M_IDLE;
        M_BLOCK: begin
          if (c == "/" && st_i.pend == "*") u1.st.mode = M_IDLE;
          else u1.st.pend = c;
        end
        M_LIT: redo_lit = 1'b1;
        M_ESC: begin
          if (c == "x") begin
            u1.st.eval = 9'd0;
            u1.st.mode = M_HEX1;
          end else if (c >= "0" && c <= "7") begin
            u1.st.eval = {6'd0, c[2:0]};
            u1.st.edig = 2'd1;
            u1.st.mode = M_OCT;
          end else begin
            unique case (c)
              "a": u1 = f_litbyte(st_i, 8'd7, E_NONE);
              "b": u1 = f_litbyte(st_i, 8'd8, E_NONE);
              "f": u1 = f_litbyte(st_i, 8'd12, E_NONE);
              "n": u1 = f_litbyte(st_i, 8'd10, E_NONE);
              "t": u1 = f_litbyte(st_i, 8'd9, E_NONE);
              "v": u1 = f_litbyte(st_i, 8'd11, E_NONE);
              ChBslash, ChDquote, ChSquote: u1 = f_litbyte(st_i, c, E_NONE);
              default: u1 = f_litbyte(st_i, c, E_ESCAPE);
            endcase
            u1.st.mode = M_LIT;
          end
        end
        M_HEX1: begin
          if (!is_hex(c)) begin
            u1 = f_fatal(st_i, E_NO_HEX);
          end else begin
            u1.st.eval = {5'd0, h};
            u1.st.mode = M_HEX2;
          end
        end
        M_HEX2: begin
          if (is_hex(c)) u1 = f_litbyte(st_i, {st_i.eval[3:0], h}, E_NONE);
          else begin
            u1 = f_litbyte(st_i, st_i.eval[7:0], E_NONE);
            redo_lit = 1'b1;
          end
          u1.st.mode = M_LIT;
        end
        M_OCT: begin
          if (c >= "0" && c <= "7") begin
            u1.st.eval = oct_v;
            u1.st.edig = st_i.edig + 2'd1;
            if (st_i.edig >= 2'd2) begin
              u1 = f_litbyte(st_i, oct_v[7:0], E_NONE);
              u1.st.mode = M_LIT;
            end
          end else begin
            u1 = f_litbyte(st_i, st_i.eval[7:0], E_NONE);
            u1.st.mode = M_LIT;
            redo_lit = 1'b1;
          end
        end
        default: begin
          u1.st.mode = M_IDLE;
          redo_idle = 1'b1;
        end
      endcase
    end

    u2 = '0;
    u2.st = u1.st;
    if (redo_idle) u2 = f_idle(u1.st, c);
    else if (redo_lit) u2 = f_lit(u1.st, c);
    if (!st_i.halted && eoi_i && !fatal) u2.em = mk(K_END, 64'd0, E_NONE);

    st_o = u2.st;
    wr_o = u1.wr.v ? u1.wr : u2.wr;
    push_o = '0;
    if (u1.em.v) begin
      push_o.r0 = u1.em.r;
      push_o.r1 = u2.em.r;
      push_o.cnt = u2.em.v ? 2'd2 : 2'd1;
    end else begin
      push_o.r0 = u2.em.r;
      push_o.cnt = u2.em.v ? 2'd1 : 2'd0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/stl_outq.sv
// result queue taking up to two results per cycle and giving up to one
`default_nettype none
`include "source_token_lexer_macros.svh"
module stl_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_en,
  input  stl_pkg::stl_push_t push_i,
  input  logic               pop,
  output logic               room2,
  output logic               valid_o,
  output stl_pkg::stl_res_t  res_o,
  output logic               last_o
);
  import stl_pkg::*;

  typedef struct packed {
    stl_res_t r;
    logic     last;
  } stl_ent_t;

  stl_ent_t             mem_r [QDepth];
  logic [QPtrW-1:0]     wp_r, rp_r;
  logic [QCntW-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           n_in;

  assign n_in    = push_en ? push_i.cnt : 2'd0;
  assign room2   = cnt_r <= QCntW'(QDepth - 2);
  assign valid_o = cnt_r != '0;
  assign res_o   = mem_r[rp_r].r;
  assign last_o  = mem_r[rp_r].last;
  assign cnt_nxt = cnt_r + QCntW'(n_in) - QCntW'(pop && valid_o);

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem_r[wp_r] <= '{r: push_i.r0, last: (n_in == 2'd1)};
    end
    if (n_in == 2'd2) begin
      mem_r[wp_r + QPtrW'(1)] <= '{r: push_i.r1, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + QPtrW'(n_in);
      if (pop && valid_o) rp_r <= rp_r + QPtrW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  `STL_ASSERT_SAME(a_no_overflow, push_en, cnt_r <= QCntW'(QDepth - 2))
  `STL_ASSERT_NEXT(a_cnt_track, !push_en && !pop && valid_o, cnt_r == $past(cnt_r))
  `STL_ASSERT_SAME(a_pop_needs_data, pop, valid_o)

endmodule
`default_nettype wire

// File: rtl/core/source_token_lexer.sv
// top level of the source token lexer
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  in       | in_valid / in_ready     | in_byte, in_end_of_input
//  out      | out_valid / out_ready   | out_kind, out_value, out_error_code,
//           |                         | out_last
//
//  one character per cycle while the queue has room: an input register feeds the
//  step logic, whose results go into a four-entry queue; a character with two
//  results leaves one extra entry, which the queue absorbs while out_ready stays high
//  the input register holds its character while the queue has fewer than two
//  free entries
//  rst_n clears the lexer state and empties the queue; the word buffer is
//  not cleared
`default_nettype none
`include "source_token_lexer_macros.svh"
module source_token_lexer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_end_of_input,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_kind,
  output logic signed [63:0] out_value,
  output logic [2:0]         out_error_code,
  output logic               out_last
);
  import stl_pkg::*;

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_eoi_r;

  // lexer state and word buffer
  stl_state_t              st_r, st_nxt;
  logic [WordDepth*8-1:0]  wbuf_r;
  stl_wr_t                 wr;
  stl_push_t               push;
  stl_res_t                head;

  logic fire, room2, pop;

  // a character is processed once the queue can take both possible results
  assign fire     = in_v_r && room2;
  assign in_ready = !in_v_r || fire;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
      in_eoi_r  <= in_end_of_input;
    end
  end

  stl_step u_step (
    .st_i   (st_r),
    .wbuf_i (wbuf_r),
    .byte_i (in_byte_r),
    .eoi_i  (in_eoi_r),
    .st_o   (st_nxt),
    .wr_o   (wr),
    .push_o (push)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // identifier bytes, written at the current word length
  always_ff @(posedge clk) begin
    if (fire && wr.v) begin
      wbuf_r[wr.addr*8 +: 8] <= in_byte_r;
    end
  end

  stl_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (fire),
    .push_i  (push),
    .pop     (pop),
    .room2   (room2),
    .valid_o (out_valid),
    .res_o   (head),
    .last_o  (out_last)
  );

  assign out_kind       = head.kind;
  assign out_value      = $signed(head.value);
  assign out_error_code = head.err;

  // once halted, no character adds results
  `STL_ASSERT_SAME(a_halt_silent, fire && st_r.halted, push.cnt == 2'd0)
  // a waiting character keeps its value
  `STL_ASSERT_NEXT(a_hold_input, in_v_r && !fire, in_v_r && $stable(in_byte_r))
  // halting only follows a processed character
  `STL_ASSERT_SAME(a_halt_cause, $rose(st_r.halted), $past(fire))

endmodule
`default_nettype wire

// File: tb/source_token_lexer_checker.sv
// transfer monitor, token predictor and result comparison for the source token lexer
`timescale 1ns / 1ps
module source_token_lexer_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_end_of_input,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [4:0]         out_kind,
  input  logic signed [63:0] out_value,
  input  logic [2:0]         out_error_code,
  input  logic               out_last,
  output int                 fail_count,
  output int                 tokens_waiting,
  output int                 results_seen,
  output int                 text_seen,
  output int                 sources_ended
);
  import stl_pkg::*;

  typedef struct {
    logic [4:0]  kind;
    logic [63:0] value;
    logic [2:0]  err;
    logic        last;
  } token_t;

  token_t tokens_due[$];

  string keywords[19] = '{"as", "break", "case", "continue", "default", "define", "else",
    "fallthrough", "false", "for", "goto", "if", "include", "nil", "return", "sizeof",
    "switch", "true", "type"};

  logic [3:0]  mode;
  logic [7:0]  pend;
  logic [7:0]  word[WordDepth];
  int          wlen;
  bit          wlong;
  logic [63:0] nval;
  logic [1:0]  nbase;
  bit          ninv;
  bit          in_string;
  logic [8:0]  esc;
  int          edig;
  int          ccount;
  logic [7:0]  fchar;
  bit          halted;
  int          step_count;

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return letter(c) || digit(c);
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // -1 when not a hex digit
  function automatic int hex_of(logic [7:0] c);
    if (digit(c)) return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic bit op_lead(logic [7:0] c);
    return c == "*" || c == "%" || c == "~" || c == "=" || c == "!" || c == "<" ||
           c == ">" || c == "+" || c == "-" || c == "|" || c == "&" || c == "." || c == "/";
  endfunction

  function automatic logic [4:0] two_char_op(logic [7:0] p, logic [7:0] c);
    if (c == "=") begin
      case (p)
        "*": return OP_STAR_EQ;
        "%": return OP_PCT_EQ;
        "~": return OP_TILDE_EQ;
        "=": return OP_EQ_EQ;
        "!": return OP_NOT_EQ;
        "<": return OP_LE;
        ">": return OP_GE;
        "+": return OP_ADD_EQ;
        "-": return OP_SUB_EQ;
        "|": return OP_OR_EQ;
        "&": return OP_AND_EQ;
        "/": return OP_DIV_EQ;
        default: return 5'd0;
      endcase
    end
    if (c == p) begin
      case (p)
        "+": return OP_INC;
        "-": return OP_DEC;
        "|": return OP_LOR;
        "&": return OP_LAND;
        default: return 5'd0;
      endcase
    end
    return 5'd0;
  endfunction

  task automatic push_token(logic [4:0] k, logic [63:0] v, logic [2:0] e);
    token_t t;
    if (step_count < 2) begin
      t.kind = k;
      t.value = v;
      t.err = e;
      t.last = 1'b0;
      tokens_due.push_back(t);
      step_count++;
    end
  endtask

  task automatic clear_lexer();
    mode = M_IDLE;
    pend = '0;
    wlen = 0;
    wlong = 0;
    nval = '0;
    nbase = B_DEC;
    ninv = 0;
    in_string = 0;
    esc = '0;
    edig = 0;
    ccount = 0;
    fchar = '0;
  endtask

  task automatic close_word();
    bit hit;
    int idx;
    hit = 0;
    idx = 0;
    if (!wlong) begin
      for (int i = 0; i < 19; i++) begin
        if (!hit && keywords[i].len() == wlen) begin
          hit = 1;
          for (int k = 0; k < wlen; k++)
            if (word[k] != keywords[i][k]) hit = 0;
          if (hit) idx = i;
        end
      end
    end
    if (hit) push_token(K_KEYWORD, 64'(idx), E_NONE);
    else push_token(K_IDENT, '0, E_NONE);
    mode = M_IDLE;
  endtask

  task automatic close_number();
    push_token(K_NUMBER, nval, ninv ? E_BAD_NUM : E_NONE);
    mode = M_IDLE;
  endtask

  task automatic literal_fatal(logic [2:0] e);
    push_token(in_string ? K_STRING : K_NUMBER, '0, e);
    halted = 1;
    mode = M_IDLE;
  endtask

  task automatic literal_byte(logic [7:0] b, logic [2:0] e);
    push_token(K_TEXT, 64'(b), e);
    if (ccount == 0) fchar = b;
    if (ccount < 2) ccount++;
  endtask

  task automatic begin_token(logic [7:0] c);
    if (blank(c)) return;
    if (letter(c)) begin
      word[0] = c;
      wlen = 1;
      wlong = 0;
      push_token(K_TEXT, 64'(c), E_NONE);
      mode = M_IDENT;
    end else if (digit(c)) begin
      nval = 64'(c - "0");
      nbase = B_DEC;
      ninv = 0;
      mode = (c == "0") ? M_NUM_ZERO : M_NUM;
    end else if (c == ChSquote || c == ChDquote) begin
      in_string = (c == ChDquote);
      ccount = 0;
      fchar = '0;
      mode = M_LIT;
    end else if (op_lead(c)) begin
      pend = c;
      mode = M_OP1;
    end else begin
      push_token(K_SINGLE, 64'(c), E_NONE);
    end
  endtask

  task automatic literal_char(logic [7:0] c);
    if (c == ChNl) begin
      literal_fatal(E_UNTERM);
    end else if (c == (in_string ? ChDquote : ChSquote)) begin
      mode = M_IDLE;
      if (in_string) push_token(K_STRING, '0, E_NONE);
      else if (ccount == 0) push_token(K_NUMBER, '0, E_EMPTY);
      else if (ccount == 1) push_token(K_NUMBER, 64'(fchar), E_NONE);
      else begin
        push_token(K_NUMBER, 64'(fchar), E_MULTI);
        halted = 1;
      end
    end else if (c == ChBslash) begin
      mode = M_ESC;
    end else begin
      literal_byte(c, E_NONE);
    end
  endtask

  task automatic feed_char(logic [7:0] c);
    int h;
    logic [4:0] op;
    logic [63:0] radix;
    logic [63:0] d;
    h = hex_of(c);
    case (mode)
      M_IDENT: begin
        if (word_char(c)) begin
          if (wlen < WordDepth) begin
            word[wlen] = c;
            wlen++;
          end else wlong = 1;
          push_token(K_TEXT, 64'(c), E_NONE);
        end else begin
          close_word();
          begin_token(c);
        end
      end
      M_NUM_ZERO: begin
        if (c == "x" || c == "X") mode = M_NUM_HEXPFX;
        else if (word_char(c)) begin
          nbase = B_OCT;
          mode = M_NUM;
          if (c >= "0" && c <= "7") nval = 64'(c - "0");
          else ninv = 1;
        end else begin
          close_number();
          begin_token(c);
        end
      end
      M_NUM_HEXPFX: begin
        if (h >= 0) begin
          nbase = B_HEX;
          nval = 64'(h);
          mode = M_NUM;
        end else if (word_char(c)) begin
          nbase = B_HEX;
          ninv = 1;
          mode = M_NUM;
        end else begin
          ninv = 1;
          close_number();
          begin_token(c);
        end
      end
      M_NUM: begin
        radix = (nbase == B_OCT) ? 64'd8 : (nbase == B_HEX) ? 64'd16 : 64'd10;
        if (!ninv && h >= 0 && 64'(h) < radix) begin
          d = 64'(h);
          // saturate at the largest signed value
          if (nval > (I64Max - d) / radix) nval = I64Max;
          else nval = nval * radix + d;
        end else if (word_char(c)) ninv = 1;
        else begin
          close_number();
          begin_token(c);
        end
      end
      M_OP1: begin
        op = two_char_op(pend, c);
        if (op != 5'd0) begin
          push_token(op, '0, E_NONE);
          mode = M_IDLE;
        end else if (c == pend && (c == "<" || c == ">" || c == ".")) mode = M_OP2;
        else if (pend == "/" && c == "/") mode = M_LINE;
        else if (pend == "/" && c == "*") begin
          pend = '0;
          mode = M_BLOCK;
        end else begin
          push_token(K_SINGLE, 64'(pend), E_NONE);
          mode = M_IDLE;
          begin_token(c);
        end
      end
      M_OP2: begin
        mode = M_IDLE;
        if (pend == ".") begin
          if (c == ".") push_token(OP_ELLIPSIS, '0, E_NONE);
          else begin
            push_token(OP_DOTDOT, '0, E_NONE);
            begin_token(c);
          end
        end else if (c == "=") push_token(pend == "<" ? OP_SHL_EQ : OP_SHR_EQ, '0, E_NONE);
        else begin
          push_token(pend == "<" ? OP_SHL : OP_SHR, '0, E_NONE);
          begin_token(c);
        end
      end
      M_LINE: if (c == ChNl) mode = M_IDLE;
      M_BLOCK: begin
        if (c == "/" && pend == "*") mode = M_IDLE;
        else pend = c;
      end
      M_LIT: literal_char(c);
      M_ESC: begin
        mode = M_LIT;
        if (c == "x") begin
          esc = '0;
          mode = M_HEX1;
        end else if (c >= "0" && c <= "7") begin
          esc = 9'(c - "0");
          edig = 1;
          mode = M_OCT;
        end else begin
          case (c)
            "a": literal_byte(8'd7, E_NONE);
            "b": literal_byte(8'd8, E_NONE);
            "f": literal_byte(8'd12, E_NONE);
            "n": literal_byte(8'd10, E_NONE);
            "t": literal_byte(8'd9, E_NONE);
            "v": literal_byte(8'd11, E_NONE);
            ChBslash, ChDquote, ChSquote: literal_byte(c, E_NONE);
            default: literal_byte(c, E_ESCAPE);
          endcase
        end
      end
      M_HEX1: begin
        if (h < 0) literal_fatal(E_NO_HEX);
        else begin
          esc = 9'(h);
          mode = M_HEX2;
        end
      end
      M_HEX2: begin
        mode = M_LIT;
        if (h >= 0) literal_byte(8'(esc * 16 + h), E_NONE);
        else begin
          literal_byte(esc[7:0], E_NONE);
          literal_char(c);
        end
      end
      M_OCT: begin
        if (c >= "0" && c <= "7") begin
          esc = esc * 9'd8 + 9'(c - "0");
          edig++;
          if (edig >= 3) begin
            literal_byte(esc[7:0], E_NONE);
            mode = M_LIT;
          end
        end else begin
          literal_byte(esc[7:0], E_NONE);
          mode = M_LIT;
          literal_char(c);
        end
      end
      default: begin
        mode = M_IDLE;
        begin_token(c);
      end
    endcase
  endtask

  task automatic feed_end();
    case (mode)
      M_IDENT: close_word();
      M_NUM_HEXPFX: begin
        ninv = 1;
        close_number();
      end
      M_NUM_ZERO, M_NUM: close_number();
      M_OP1: push_token(K_SINGLE, 64'(pend), E_NONE);
      M_OP2: begin
        if (pend == ".") push_token(OP_DOTDOT, '0, E_NONE);
        else push_token(pend == "<" ? OP_SHL : OP_SHR, '0, E_NONE);
      end
      M_LIT, M_ESC, M_HEX2, M_OCT: begin
        literal_fatal(E_UNTERM);
        return;
      end
      M_HEX1: begin
        literal_fatal(E_NO_HEX);
        return;
      end
      default: ;
    endcase
    push_token(K_END, '0, E_NONE);
    clear_lexer();
  endtask

  task automatic lex_transfer(logic [7:0] c, logic eoi);
    step_count = 0;
    if (halted) return;
    if (eoi) begin
      feed_end();
      sources_ended++;
    end else feed_char(c);
    if (step_count > 0) tokens_due[tokens_due.size()-1].last = 1'b1;
  endtask

  initial begin
    fail_count = 0;
    tokens_waiting = 0;
    results_seen = 0;
    text_seen = 0;
    sources_ended = 0;
  end

  always @(posedge clk) begin
    token_t t;
    if (!rst_n) begin
      clear_lexer();
      halted = 0;
      tokens_due.delete();
    end else begin
      // input first: a result never leaves in the cycle its character arrives
      if (in_valid && in_ready) lex_transfer(in_byte, in_end_of_input);
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_kind == K_TEXT) text_seen++;
        if (tokens_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: kind %0d value %0h err %0d last %0b",
                     out_kind, out_value, out_error_code, out_last);
        end else begin
          t = tokens_due.pop_front();
          if (out_kind !== t.kind || out_value !== t.value ||
              out_error_code !== t.err || out_last !== t.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected kind %0d value %0h err %0d last %0b",
                       t.kind, t.value, t.err, t.last);
              $display("          got      kind %0d value %0h err %0d last %0b",
                       out_kind, out_value, out_error_code, out_last);
            end
          end
        end
      end
    end
    tokens_waiting = tokens_due.size();
  end

endmodule

// File: tb/tb_source_token_lexer.sv
// top of the source token lexer testbench: clock, reset, source text and verdict
`timescale 1ns / 1ps
module tb_source_token_lexer;
  import stl_pkg::*;

  localparam int SourceItems = 650;
  localparam int QuietLimit  = 3000;
  localparam int HoldCycles  = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte = '0;
  logic               in_end_of_input = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [4:0]         out_kind;
  logic signed [63:0] out_value;
  logic [2:0]         out_error_code;
  logic               out_last;

  int fail_count, tokens_waiting, results_seen, text_seen, sources_ended;
  int items_sent = 0;
  int quiet = 0;
  bit calm = 0;       // no idling on either side while set
  bit hold_req = 0;   // asks the receiver for its one long hold-off
  bit hold_done = 0;

  // fragment classes of the random source text
  typedef enum int {FR_IDENT, FR_KEYWORD, FR_NUMBER, FR_STRING, FR_CHAR, FR_OP,
                    FR_COMMENT, FR_NOISE, FR_END} frag_t;

  logic [8:0] src[$];   // {end marker, byte}

  string keywords[19] = '{"as", "break", "case", "continue", "default", "define", "else",
    "fallthrough", "false", "for", "goto", "if", "include", "nil", "return", "sizeof",
    "switch", "true", "type"};
  string operators[31] = '{"*=", "%=", "~=", "==", "!=", "<<=", ">>=", "<<", ">>", "<=",
    ">=", "+=", "-=", "|=", "&=", "++", "--", "||", "&&", "...", "..", "/=",
    "*", "%", "~", "=", "!", "<", ">", "+", "-"};
  string hex_digits = "0123456789abcdefABCDEF";
  string blanks = " \t\n\v\f\r";

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  source_token_lexer dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_byte, .in_end_of_input,
    .out_valid, .out_ready, .out_kind, .out_value, .out_error_code, .out_last
  );

  source_token_lexer_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_byte, .in_end_of_input,
    .out_valid, .out_ready, .out_kind, .out_value, .out_error_code, .out_last,
    .fail_count, .tokens_waiting, .results_seen, .text_seen, .sources_ended
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] any_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] any_word_char();
    if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
    return any_letter();
  endfunction

  task automatic put(logic [7:0] b);
    src.push_back({1'b0, b});
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_blank();
    repeat ($urandom_range(1, 3)) put(blanks[$urandom_range(0, 5)]);
  endtask

  // any byte that may stand bare inside a literal
  function automatic logic [7:0] plain_byte(logic [7:0] quote);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ChNl || b == quote || b == ChBslash);
    return b;
  endfunction

  // one literal element: a bare byte or an escape of every flavour
  task automatic put_literal_item(logic [7:0] quote);
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: begin
        put(ChBslash);
        put_text("x");
        put(hex_digits[$urandom_range(0, 21)]);
        if ($urandom_range(0, 1)) put(hex_digits[$urandom_range(0, 21)]);
      end
      1: begin
        put(ChBslash);
        repeat ($urandom_range(1, 3)) put(8'("0" + $urandom_range(0, 7)));
      end
      2: begin
        put(ChBslash);
        case ($urandom_range(0, 9))
          0: put_text("a");
          1: put_text("b");
          2: put_text("f");
          3: put_text("n");
          4: put_text("t");
          5: put_text("v");
          6: put(ChBslash);
          7: put(ChDquote);
          8: put(ChSquote);
          // unknown escape, or a backslash or quote escape: any byte that opens no hex, octal or letter escape
          default: begin
            do b = 8'($urandom_range(0, 255));
            while (b == "x" || (b >= "0" && b <= "7") || b == "a" || b == "b" ||
                   b == "f" || b == "n" || b == "t" || b == "v");
            put(b);
          end
        endcase
      end
      default: put(plain_byte(quote));
    endcase
  endtask

  task automatic make_fragment(frag_t f);
    logic [7:0] b;
    case (f)
      FR_IDENT: begin
        put(any_letter());
        repeat ($urandom_range(0, 2) == 0 ? $urandom_range(9, 15) : $urandom_range(0, 5))
          put(any_word_char());
      end
      FR_KEYWORD: begin
        put_text(keywords[$urandom_range(0, 18)]);
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) put(any_word_char());
      end
      FR_NUMBER: begin
        case ($urandom_range(0, 3))
          0: begin
            put(8'("1" + $urandom_range(0, 8)));
            repeat ($urandom_range(0, 1) ? $urandom_range(17, 22) : $urandom_range(0, 4))
              put(8'("0" + $urandom_range(0, 9)));
          end
          1: begin
            put_text("0");
            repeat ($urandom_range(0, 8)) put(8'("0" + $urandom_range(0, 7)));
          end
          default: begin
            put_text($urandom_range(0, 1) ? "0x" : "0X");
            repeat ($urandom_range(0, 18)) put(hex_digits[$urandom_range(0, 21)]);
          end
        endcase
        // trailing junk
        if ($urandom_range(0, 5) == 0) put(any_word_char());
      end
      FR_STRING: begin
        put(ChDquote);
        repeat ($urandom_range(0, 6)) put_literal_item(ChDquote);
        put(ChDquote);
      end
      FR_CHAR: begin
        put(ChSquote);
        if ($urandom_range(0, 5) != 0) put_literal_item(ChSquote);
        put(ChSquote);
      end
      FR_OP: begin
        if ($urandom_range(0, 5) == 0) put_text($urandom_range(0, 1) ? "/" : ".");
        else put_text(operators[$urandom_range(0, 30)]);
      end
      FR_COMMENT: begin
        if ($urandom_range(0, 1)) begin
          put_text("//");
          repeat ($urandom_range(0, 8)) begin
            do b = 8'($urandom_range(0, 255)); while (b == ChNl);
            put(b);
          end
          put(ChNl);
        end else begin
          put_text("/*");
          repeat ($urandom_range(0, 8)) begin
            do b = 8'($urandom_range(0, 255)); while (b == "*");
            put(b);
          end
          put_text("*/");
        end
      end
      FR_NOISE: begin
        do b = 8'($urandom_range(0, 255)); while (b == ChDquote || b == ChSquote);
        put(b);
      end
      default: src.push_back({1'b1, 8'($urandom_range(0, 255))});
    endcase
  endtask

  task automatic send_item(logic [8:0] it);
    int g;
    g = idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= it[7:0];
    in_end_of_input <= it[8];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (items_sent == 250) hold_req = 1;
  endtask

  task automatic send_source();
    while (src.size() > 0) send_item(src.pop_front());
  endtask

  // receiver: random back-pressure plus one long hold-off so the block fills up
  initial begin : receiver
    int g;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1;
      end
      g = idle_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // watchdog: any transfer on either channel counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else if (quiet >= QuietLimit) begin
        $display("[source_token_lexer] ERROR");
        $finish;
      end else quiet <= quiet + 1;
    end
  end

  initial begin : sender
    frag_t f;
    bit after_word;
    int r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keyword edges, bad numbers, empty char, escapes, operator lookahead,
    // comments, extreme bytes and an end marker that flushes a pending operator
    put_text("fallthrough if 0x1g 0x 09 '' '");
    put(ChBslash);
    put_text("a' ");
    put(ChDquote);
    put(ChBslash);
    put_text("x4g");
    put(ChBslash);
    put_text("777");
    put(ChBslash);
    put_text("q");
    put(ChDquote);
    put_text(" a+b<<=c ... /*x*/ //y");
    put(ChNl);
    put(8'h00);
    put(8'h20);
    put(8'hFF);
    put_text(" >>");
    src.push_back({1'b1, 8'hA5});
    send_source();

    // random source text, mostly well formed
    after_word = 0;
    while (items_sent < SourceItems) begin
      if ($urandom_range(0, 11) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 14) f = FR_IDENT;
      else if (r < 24) f = FR_KEYWORD;
      else if (r < 38) f = FR_NUMBER;
      else if (r < 48) f = FR_STRING;
      else if (r < 56) f = FR_CHAR;
      else if (r < 80) f = FR_OP;
      else if (r < 87) f = FR_COMMENT;
      else if (r < 96) f = FR_NOISE;
      else f = FR_END;
      // words run straight into operators; an end may flush a pending token
      if (!((after_word && f == FR_OP) || (f == FR_END && $urandom_range(0, 1))))
        put_blank();
      make_fragment(f);
      after_word = (f == FR_IDENT || f == FR_KEYWORD || f == FR_NUMBER);
      send_source();
    end

    // a fatal literal error last, as the block stays halted until reset
    put_blank();
    case ($urandom_range(0, 3))
      0: begin
        put(ChDquote);
        put_text("ab");
        put(ChNl);
      end
      1: begin
        put(ChDquote);
        put(ChBslash);
        put_text("xz");
      end
      2: begin
        put(ChSquote);
        put_text("ab");
        put(ChSquote);
      end
      default: begin
        put(ChDquote);
        put_text("ab");
        src.push_back({1'b1, 8'h00});
      end
    endcase
    send_source();
    in_valid <= 1'b0;

    while (tokens_waiting != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("lexed %0d source transfers over %0d ends of source", items_sent, sources_ended);
    $display("checked %0d results, %0d of them text bytes", results_seen, text_seen);
    if (fail_count == 0) begin
      $display("[source_token_lexer] OK");
    end else begin
      $display("[source_token_lexer] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/stl_pkg.sv
rtl/core/stl_step.sv
rtl/core/stl_outq.sv
rtl/core/source_token_lexer.sv
tb/source_token_lexer_checker.sv
tb/tb_source_token_lexer.sv
